FILE: rtl/pbe_pkg.sv
// Package with types and constants for the PCI bus enumeration block.
package pbe_pkg;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_HDR   = 4'd1,
    PH_ID    = 4'd2,
    PH_CLASS = 4'd3,
    PH_LINE  = 4'd4,
    PH_PIN   = 4'd5,
    PH_ORIG  = 4'd6,
    PH_ORIGH = 4'd7,
    PH_WRH   = 4'd8,
    PH_WRL   = 4'd9,
    PH_MASK  = 4'd10,
    PH_MASKH = 4'd11,
    PH_RSTL  = 4'd12,
    PH_RSTH  = 4'd13
  } phase_t;

  localparam logic [2:0] KIND_RD   = 3'd0;
  localparam logic [2:0] KIND_WR   = 3'd1;
  localparam logic [2:0] KIND_FUNC = 3'd2;
  localparam logic [2:0] KIND_BAR  = 3'd3;
  localparam logic [2:0] KIND_DONE = 3'd4;

  localparam logic CMD_START = 1'b0;

  localparam logic [7:0] OFF_ID    = 8'h00;
  localparam logic [7:0] OFF_CLASS = 8'h08;
  localparam logic [7:0] OFF_HDR   = 8'h0c;
  localparam logic [7:0] OFF_BAR0  = 8'h10;
  localparam logic [7:0] OFF_LINE  = 8'h3c;
  localparam logic [7:0] OFF_PIN   = 8'h3d;

  localparam int MAXRES = 3;

  typedef struct packed {
    logic        cmd;
    logic [31:0] rsp_data;
    logic        rsp_error;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  out_kind;
    logic [31:0] cfg_address;
    logic [63:0] data_word;
    logic [4:0]  slot_num;
    logic [2:0]  function_num;
    logic [2:0]  bar_index;
    logic [2:0]  bar_flags;
    logic [63:0] bar_size;
    logic [15:0] irq_info;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  count;
    out_item_t   r0;
    out_item_t   r1;
    out_item_t   r2;
  } result_set_t;

endpackage

FILE: rtl/pbe_if.sv
// Valid/ready channel interfaces for the input and result beats.
interface pbe_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] rsp_data;
  logic        rsp_error;
  modport source (output valid, command, rsp_data, rsp_error, input ready);
  modport sink (input valid, command, rsp_data, rsp_error, output ready);
endinterface

interface pbe_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_kind;
  logic [31:0] cfg_address;
  logic [63:0] data_word;
  logic [4:0]  slot_num;
  logic [2:0]  function_num;
  logic [2:0]  bar_index;
  logic [2:0]  bar_flags;
  logic [63:0] bar_size;
  logic [15:0] irq_info;
  logic        last_of_run;
  modport source (output valid, out_kind, cfg_address, data_word, slot_num, function_num,
                  bar_index, bar_flags, bar_size, irq_info, last_of_run, input ready);
  modport sink (input valid, out_kind, cfg_address, data_word, slot_num, function_num,
                bar_index, bar_flags, bar_size, irq_info, last_of_run, output ready);
endinterface

FILE: rtl/pci_bus_enumeration_bar_sizing.sv
// Top level of the PCI bus enumeration and BAR sizing block.
// Each input beat is decoded combinationally into up to three result beats.
// The first result beat appears in the cycle after the input beat is taken.
// One input beat per cycle when each causes one result and the result channel is
// ready; an input causing more results holds off the next input until its last one pops.
// Reset (synchronous, rst_n low) idles the scan and clears bus_number to 0.
module pci_bus_enumeration_bar_sizing #(
  parameter int NUM_SLOTS = 32,
  parameter int MAX_FUNCS = 8,
  parameter int MAX_BARS  = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  pbe_in_if.sink      in_ch,
  pbe_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0] bus_r;
  logic       take;
  logic       empty_next;
  pbe_pkg::in_item_t   item;
  pbe_pkg::result_set_t res;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {24'd0, bus_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0) begin
      bus_r <= cfg_pwdata[7:0];
    end
  end

  assign in_ch.ready = empty_next;
  assign take = in_ch.valid && in_ch.ready;
  assign item = '{cmd: in_ch.command, rsp_data: in_ch.rsp_data, rsp_error: in_ch.rsp_error};

  pbe_core #(
    .NUM_SLOTS(NUM_SLOTS),
    .MAX_FUNCS(MAX_FUNCS),
    .MAX_BARS (MAX_BARS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (take),
    .item      (item),
    .bus_number(bus_r),
    .res       (res)
  );

  pbe_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .res       (res),
    .empty_next(empty_next),
    .out_ch    (out_ch)
  );

endmodule

FILE: rtl/pbe_core.sv
// Scan state machine: takes one beat and produces up to three results in one pass.
module pbe_core #(
  parameter int NUM_SLOTS = 32,
  parameter int MAX_FUNCS = 8,
  parameter int MAX_BARS  = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  pbe_pkg::in_item_t    item,
  input  logic [7:0]           bus_number,
  output pbe_pkg::result_set_t res
);

  pbe_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]  slot_r, slot_nxt;
  logic [2:0]  func_r, func_nxt;
  logic        multi_r, multi_nxt;
  logic [2:0]  bar_r, bar_nxt;
  logic [31:0] id_r, id_nxt;
  logic [31:0] crev_r, crev_nxt;
  logic [15:0] irq_r, irq_nxt;
  logic [31:0] ol_r, ol_nxt;
  logic [31:0] oh_r, oh_nxt;
  logic [31:0] ml_r, ml_nxt;
  logic [31:0] mh_r, mh_nxt;
  logic        mhb_r, mhb_nxt;

  pbe_pkg::out_item_t items [pbe_pkg::MAXRES];
  logic [1:0] n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pbe_pkg::PH_IDLE;
      slot_r  <= '0;
      func_r  <= '0;
      multi_r <= 1'b0;
      bar_r   <= '0;
      id_r    <= '0;
      crev_r  <= '0;
      irq_r   <= '0;
      ol_r    <= '0;
      oh_r    <= '0;
      ml_r    <= '0;
      mh_r    <= '0;
      mhb_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      slot_r  <= slot_nxt;
      func_r  <= func_nxt;
      multi_r <= multi_nxt;
      bar_r   <= bar_nxt;
      id_r    <= id_nxt;
      crev_r  <= crev_nxt;
      irq_r   <= irq_nxt;
      ol_r    <= ol_nxt;
      oh_r    <= oh_nxt;
      ml_r    <= ml_nxt;
      mh_r    <= mh_nxt;
      mhb_r   <= mhb_nxt;
    end
  end

  function automatic logic is64(input logic [31:0] ol);
    return (ol[0] == 1'b0) && (ol[2:1] == 2'b10);
  endfunction

  always_comb begin
    logic [31:0] d;
    logic        e;
    logic [3:0]  nb;
    logic [3:0]  step_b;
    logic [3:0]  nf;
    logic [5:0]  ns;
    logic        do_next_bar;
    logic        do_next_func;
    logic        do_start_slot;
    logic        do_func_rec;
    logic        do_bar_rec;
    logic        do_finish;
    logic        req_v;
    logic [2:0]  req_k;
    logic [7:0]  req_off;
    logic [31:0] req_d;
    pbe_pkg::phase_t req_ph;
    logic [7:0]  boff;
    logic [63:0] base, size;
    logic [2:0]  flags;
    logic [63:0] m64;
    pbe_pkg::out_item_t ri, fi, bi;

    d = item.rsp_data;
    e = item.rsp_error;
    phase_nxt = phase_r;
    slot_nxt = slot_r;
    func_nxt = func_r;
    multi_nxt = multi_r;
    bar_nxt = bar_r;
    id_nxt = id_r;
    crev_nxt = crev_r;
    irq_nxt = irq_r;
    ol_nxt = ol_r;
    oh_nxt = oh_r;
    ml_nxt = ml_r;
    mh_nxt = mh_r;
    mhb_nxt = mhb_r;
    nb = {1'b0, bar_r} + 4'd1;
    nf = 4'd0;
    do_next_bar = 1'b0;
    do_next_func = 1'b0;
    do_start_slot = 1'b0;
    do_func_rec = 1'b0;
    do_bar_rec = 1'b0;
    do_finish = 1'b0;
    ns = 6'd0;
    req_v = 1'b0;
    req_k = pbe_pkg::KIND_RD;
    req_off = pbe_pkg::OFF_ID;
    req_d = '0;
    req_ph = pbe_pkg::PH_IDLE;
    boff = pbe_pkg::OFF_BAR0 + {3'd0, bar_r, 2'b00};
    base = '0;
    size = '0;
    flags = '0;
    step_b = 4'd1;
    m64 = '0;

    if (item.cmd == pbe_pkg::CMD_START) begin
      multi_nxt = 1'b0;
      do_start_slot = 1'b1;
      ns = 6'd0;
    end else begin
      case (phase_r)
        pbe_pkg::PH_HDR: begin
          multi_nxt = !e && d[23];
          func_nxt = '0;
          req_v = 1'b1; req_off = pbe_pkg::OFF_ID; req_ph = pbe_pkg::PH_ID;
        end
        pbe_pkg::PH_ID: begin
          id_nxt = e ? 32'hffff_ffff : d;
          req_v = 1'b1; req_off = pbe_pkg::OFF_CLASS; req_ph = pbe_pkg::PH_CLASS;
        end
        pbe_pkg::PH_CLASS: begin
          if (e || id_r[15:0] == 16'hffff) begin
            do_next_func = 1'b1;
          end else begin
            crev_nxt = d;
            req_v = 1'b1; req_off = pbe_pkg::OFF_LINE; req_ph = pbe_pkg::PH_LINE;
          end
        end
        pbe_pkg::PH_LINE: begin
          irq_nxt = {8'd0, e ? 8'hff : d[7:0]};
          req_v = 1'b1; req_off = pbe_pkg::OFF_PIN; req_ph = pbe_pkg::PH_PIN;
        end
        pbe_pkg::PH_PIN: begin
          irq_nxt = {e ? 8'hff : d[15:8], irq_r[7:0]};
          nb = 4'd0;
          do_next_bar = 1'b1;
        end
        pbe_pkg::PH_ORIG: begin
          if (e || d == 32'd0) begin
            do_next_bar = 1'b1;
          end else begin
            ol_nxt = d;
            mhb_nxt = 1'b0;
            mh_nxt = '0;
            if (is64(d)) begin
              if (nb >= 4'(MAX_BARS)) begin
                do_next_bar = 1'b1;
              end else begin
                req_v = 1'b1; req_off = boff + 8'd4; req_ph = pbe_pkg::PH_ORIGH;
              end
            end else begin
              req_v = 1'b1; req_k = pbe_pkg::KIND_WR; req_off = boff;
              req_d = 32'hffff_ffff; req_ph = pbe_pkg::PH_WRL;
            end
          end
        end
        pbe_pkg::PH_ORIGH: begin
          if (e) begin
            do_next_bar = 1'b1;
          end else begin
            oh_nxt = d;
            req_v = 1'b1; req_k = pbe_pkg::KIND_WR; req_off = boff + 8'd4;
            req_d = 32'hffff_ffff; req_ph = pbe_pkg::PH_WRH;
          end
        end
        pbe_pkg::PH_WRH: begin
          req_v = 1'b1; req_k = pbe_pkg::KIND_WR; req_off = boff;
          req_d = 32'hffff_ffff; req_ph = pbe_pkg::PH_WRL;
        end
        pbe_pkg::PH_WRL: begin
          req_v = 1'b1; req_off = boff; req_ph = pbe_pkg::PH_MASK;
        end
        pbe_pkg::PH_MASK: begin
          ml_nxt = e ? 32'd0 : d;
          if (is64(ol_r)) begin
            req_v = 1'b1; req_off = boff + 8'd4; req_ph = pbe_pkg::PH_MASKH;
          end else begin
            req_v = 1'b1; req_k = pbe_pkg::KIND_WR; req_off = boff;
            req_d = ol_r; req_ph = pbe_pkg::PH_RSTL;
          end
        end
        pbe_pkg::PH_MASKH: begin
          mhb_nxt = e;
          mh_nxt = e ? 32'd0 : d;
          req_v = 1'b1; req_k = pbe_pkg::KIND_WR; req_off = boff;
          req_d = ol_r; req_ph = pbe_pkg::PH_RSTL;
        end
        pbe_pkg::PH_RSTL: begin
          if (is64(ol_r)) begin
            req_v = 1'b1; req_k = pbe_pkg::KIND_WR; req_off = boff + 8'd4;
            req_d = oh_r; req_ph = pbe_pkg::PH_RSTH;
          end else begin
            do_finish = 1'b1;
          end
        end
        pbe_pkg::PH_RSTH: do_finish = 1'b1;
        default: phase_nxt = pbe_pkg::PH_IDLE;
      endcase
    end

    if (do_finish) begin
      if (ml_r == 32'd0) begin
        do_next_bar = 1'b1;
      end else if (ol_r[0]) begin
        base = {32'd0, ol_r[31:2], 2'b00};
        size = {32'd0, ~{ml_r[31:2], 2'b00} + 32'd1};
        flags = 3'b001;
        do_bar_rec = 1'b1;
        do_next_bar = 1'b1;
      end else if (ol_r[2:1] == 2'b10 && mhb_r) begin
        do_next_bar = 1'b1;
      end else begin
        if (ol_r[2:1] == 2'b10) begin
          base = {oh_r, ol_r[31:4], 4'd0};
          m64 = {mh_r, ml_r[31:4], 4'd0};
          size = ~m64 + 64'd1;
          flags[1] = 1'b1;
          step_b = 4'd2;
        end else begin
          base = {32'd0, ol_r[31:4], 4'd0};
          size = {32'd0, ~{ml_r[31:4], 4'd0} + 32'd1};
        end
        flags[2] = ol_r[3];
        do_bar_rec = 1'b1;
        do_next_bar = 1'b1;
      end
      nb = {1'b0, bar_r} + step_b;
    end

    if (do_next_bar) begin
      if (nb >= 4'(MAX_BARS)) begin
        do_func_rec = 1'b1;
        do_next_func = 1'b1;
      end else begin
        bar_nxt = nb[2:0];
        req_v = 1'b1; req_k = pbe_pkg::KIND_RD;
        req_off = pbe_pkg::OFF_BAR0 + {2'd0, nb, 2'b00};
        req_d = '0; req_ph = pbe_pkg::PH_ORIG;
      end
    end

    if (do_next_func) begin
      nf = {1'b0, func_r} + 4'd1;
      if (nf < (multi_r ? 4'(MAX_FUNCS) : 4'd1)) begin
        func_nxt = nf[2:0];
        req_v = 1'b1; req_k = pbe_pkg::KIND_RD; req_off = pbe_pkg::OFF_ID;
        req_d = '0; req_ph = pbe_pkg::PH_ID;
      end else begin
        do_start_slot = 1'b1;
        ns = {1'b0, slot_r} + 6'd1;
      end
    end

    if (do_start_slot) begin
      if (ns >= 6'(NUM_SLOTS)) begin
        phase_nxt = pbe_pkg::PH_IDLE;
      end else begin
        slot_nxt = ns[4:0];
        func_nxt = '0;
        req_v = 1'b1; req_k = pbe_pkg::KIND_RD; req_off = pbe_pkg::OFF_HDR;
        req_d = '0; req_ph = pbe_pkg::PH_HDR;
      end
    end
    if (req_v) phase_nxt = req_ph;

    ri = '0;
    ri.out_kind = req_k;
    ri.cfg_address = {8'h80, bus_number, slot_nxt, func_nxt, req_off[7:2], 2'b00};
    ri.data_word = {32'd0, req_d};
    ri.slot_num = slot_nxt;
    ri.function_num = func_nxt;

    fi = '0;
    fi.out_kind = pbe_pkg::KIND_FUNC;
    fi.data_word = {crev_r[7:0], crev_r[31:8], id_nxt};
    fi.slot_num = slot_r;
    fi.function_num = func_r;
    fi.irq_info = irq_nxt;

    bi = '0;
    bi.out_kind = pbe_pkg::KIND_BAR;
    bi.data_word = base;
    bi.slot_num = slot_r;
    bi.function_num = func_r;
    bi.bar_index = bar_r;
    bi.bar_flags = flags;
    bi.bar_size = size;

    if (!req_v && do_start_slot) begin
      ri = '0;
      ri.out_kind = pbe_pkg::KIND_DONE;
    end

    n = 2'd0;
    items[0] = '0;
    items[1] = '0;
    items[2] = '0;
    if (do_bar_rec) begin
      items[n] = bi;
      n = n + 2'd1;
    end
    if (do_func_rec) begin
      items[n] = fi;
      n = n + 2'd1;
    end
    if (req_v || do_start_slot) begin
      items[n] = ri;
      n = n + 2'd1;
    end
    if (n != 2'd0) items[n - 2'd1].last_of_run = 1'b1;
    res.count = n;
    res.r0 = items[0];
    res.r1 = items[1];
    res.r2 = items[2];
  end

endmodule

FILE: rtl/pbe_outq.sv
// Result buffer: holds up to three result beats per input and drains one per cycle while the result channel is ready.
module pbe_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  pbe_pkg::result_set_t res,
  output logic                 empty_next,
  pbe_out_if.source            out_ch
);

  pbe_pkg::out_item_t buf_r [pbe_pkg::MAXRES];
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] rd_r, rd_nxt;
  logic       pop;

  assign pop = out_ch.valid && out_ch.ready;
  assign empty_next = (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop);

  always_comb begin
    cnt_nxt = cnt_r;
    rd_nxt = rd_r;
    if (load) begin
      cnt_nxt = res.count;
      rd_nxt = 2'd0;
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
      rd_nxt = rd_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r[0] <= res.r0;
      buf_r[1] <= res.r1;
      buf_r[2] <= res.r2;
    end
  end

  pbe_pkg::out_item_t head;
  assign head = (rd_r == 2'd0) ? buf_r[0] : ((rd_r == 2'd1) ? buf_r[1] : buf_r[2]);

  assign out_ch.valid        = (cnt_r != 2'd0);
  assign out_ch.out_kind     = head.out_kind;
  assign out_ch.cfg_address  = head.cfg_address;
  assign out_ch.data_word    = head.data_word;
  assign out_ch.slot_num     = head.slot_num;
  assign out_ch.function_num = head.function_num;
  assign out_ch.bar_index    = head.bar_index;
  assign out_ch.bar_flags    = head.bar_flags;
  assign out_ch.bar_size     = head.bar_size;
  assign out_ch.irq_info     = head.irq_info;
  assign out_ch.last_of_run  = head.last_of_run;

endmodule

FILE: sim/pci_bus_enumeration_bar_sizing_tb.sv
// Testbench for the PCI bus enumeration block: directed and random completions, checked beat by beat.
module pci_bus_enumeration_bar_sizing_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  pbe_in_if in_if();
  pbe_out_if out_if();

  pci_bus_enumeration_bar_sizing dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  localparam int SLOT_COUNT = 32;
  localparam int FUNC_COUNT = 8;
  localparam int BAR_COUNT = 6;
  localparam logic [1:0] REG_BUS_NUMBER = 2'd0;
  localparam logic CMD_DONE_ACCESS = 1'b1;

  pbe_pkg::in_item_t completion_q[$];
  pbe_pkg::out_item_t want_beats[$];
  pbe_pkg::out_item_t step_beats[$];
  int mismatches = 0;
  int out_count = 0;
  logic in_took = 1'b0;
  logic calm = 1'b0;

  // Shadow copy of the enumeration state.
  logic [7:0]  bus_sh;
  pbe_pkg::phase_t phase_sh;
  logic [4:0]  slot_sh;
  logic [2:0]  fn_sh;
  logic        multi_sh;
  logic [2:0]  bar_sh;
  logic [31:0] id_sh, class_sh;
  logic [15:0] irq_sh;
  logic [31:0] orig_lo, orig_hi, mask_lo, mask_hi;
  logic        mask_hi_bad;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void emit(logic [2:0] kind, logic [31:0] addr, logic [63:0] data,
                               logic [2:0] bar, logic [2:0] flags, logic [63:0] size,
                               logic [15:0] irq, logic at_loc);
    pbe_pkg::out_item_t b;
    b.out_kind = kind;
    b.cfg_address = addr;
    b.data_word = data;
    b.slot_num = at_loc ? slot_sh : 5'd0;
    b.function_num = at_loc ? fn_sh : 3'd0;
    b.bar_index = bar;
    b.bar_flags = flags;
    b.bar_size = size;
    b.irq_info = irq;
    b.last_of_run = 1'b0;
    step_beats.push_back(b);
  endfunction

  function automatic void issue(logic [2:0] kind, logic [7:0] off, logic [31:0] data,
                                pbe_pkg::phase_t nxt);
    logic [31:0] addr;
    addr = {1'b1, 7'd0, bus_sh, slot_sh, fn_sh, off[7:2], 2'b00};
    emit(kind, addr, (kind == pbe_pkg::KIND_WR) ? {32'd0, data} : 64'd0, 3'd0, 3'd0, 64'd0,
         16'd0, 1'b1);
    phase_sh = nxt;
  endfunction

  function automatic logic bar_wide();
    return orig_lo[0] == 1'b0 && orig_lo[2:1] == 2'b10;
  endfunction

  function automatic logic [7:0] bar_offset();
    return pbe_pkg::OFF_BAR0 + {3'd0, bar_sh, 2'b00};
  endfunction

  function automatic void open_slot(int s);
    if (s >= SLOT_COUNT) begin
      emit(pbe_pkg::KIND_DONE, 32'd0, 64'd0, 3'd0, 3'd0, 64'd0, 16'd0, 1'b0);
      phase_sh = pbe_pkg::PH_IDLE;
    end else begin
      slot_sh = s[4:0];
      fn_sh = 3'd0;
      issue(pbe_pkg::KIND_RD, pbe_pkg::OFF_HDR, 32'd0, pbe_pkg::PH_HDR);
    end
  endfunction

  function automatic void open_function(int f);
    fn_sh = f[2:0];
    issue(pbe_pkg::KIND_RD, pbe_pkg::OFF_ID, 32'd0, pbe_pkg::PH_ID);
  endfunction

  function automatic void advance_function();
    int count;
    count = multi_sh ? FUNC_COUNT : 1;
    if (int'(fn_sh) + 1 < count) open_function(int'(fn_sh) + 1);
    else open_slot(int'(slot_sh) + 1);
  endfunction

  function automatic void open_bar(int idx);
    if (idx >= BAR_COUNT) begin
      emit(pbe_pkg::KIND_FUNC, 32'd0,
           {class_sh[7:0], class_sh[31:8], id_sh[31:16], id_sh[15:0]},
           3'd0, 3'd0, 64'd0, irq_sh, 1'b1);
      advance_function();
    end else begin
      bar_sh = idx[2:0];
      issue(pbe_pkg::KIND_RD, bar_offset(), 32'd0, pbe_pkg::PH_ORIG);
    end
  endfunction

  function automatic void close_bar();
    logic [63:0] base, size;
    logic [2:0] flags;
    int stride;
    flags = 3'd0;
    stride = 1;
    if (mask_lo == 32'd0) begin
      open_bar(int'(bar_sh) + 1);
      return;
    end
    if (orig_lo[0]) begin
      base = {32'd0, orig_lo & ~32'h3};
      size = {32'd0, ~(mask_lo & ~32'h3) + 32'd1};
      flags = 3'b001;
    end else begin
      base = {32'd0, orig_lo & ~32'hf};
      size = {32'd0, ~(mask_lo & ~32'hf) + 32'd1};
      if (orig_lo[2:1] == 2'b10) begin
        if (mask_hi_bad) begin
          open_bar(int'(bar_sh) + 1);
          return;
        end
        base = {orig_hi, orig_lo} & ~64'hf;
        size = ~({mask_hi, mask_lo} & ~64'hf) + 64'd1;
        flags[1] = 1'b1;
        stride = 2;
      end
      if (orig_lo[3]) flags[2] = 1'b1;
    end
    emit(pbe_pkg::KIND_BAR, 32'd0, base, bar_sh, flags, size, 16'd0, 1'b1);
    open_bar(int'(bar_sh) + stride);
  endfunction

  function automatic void scan_step(pbe_pkg::in_item_t it);
    logic [31:0] d;
    logic e;
    d = it.rsp_data;
    e = it.rsp_error;
    step_beats.delete();
    if (it.cmd == pbe_pkg::CMD_START) begin
      multi_sh = 1'b0;
      open_slot(0);
    end else begin
      case (phase_sh)
        pbe_pkg::PH_HDR: begin
          multi_sh = !e && d[23];
          open_function(0);
        end
        pbe_pkg::PH_ID: begin
          id_sh = e ? 32'hffffffff : d;
          issue(pbe_pkg::KIND_RD, pbe_pkg::OFF_CLASS, 32'd0, pbe_pkg::PH_CLASS);
        end
        pbe_pkg::PH_CLASS: begin
          if (e || id_sh[15:0] == 16'hffff) begin
            advance_function();
          end else begin
            class_sh = d;
            issue(pbe_pkg::KIND_RD, pbe_pkg::OFF_LINE, 32'd0, pbe_pkg::PH_LINE);
          end
        end
        pbe_pkg::PH_LINE: begin
          irq_sh = {8'd0, e ? 8'hff : d[7:0]};
          issue(pbe_pkg::KIND_RD, pbe_pkg::OFF_PIN, 32'd0, pbe_pkg::PH_PIN);
        end
        pbe_pkg::PH_PIN: begin
          irq_sh[15:8] = e ? 8'hff : d[15:8];
          open_bar(0);
        end
        pbe_pkg::PH_ORIG: begin
          if (e || d == 32'd0) begin
            open_bar(int'(bar_sh) + 1);
          end else begin
            orig_lo = d;
            mask_hi_bad = 1'b0;
            mask_hi = 32'd0;
            if (!bar_wide())
              issue(pbe_pkg::KIND_WR, bar_offset(), 32'hffffffff, pbe_pkg::PH_WRL);
            else if (int'(bar_sh) + 1 >= BAR_COUNT) open_bar(int'(bar_sh) + 1);
            else issue(pbe_pkg::KIND_RD, bar_offset() + 8'd4, 32'd0, pbe_pkg::PH_ORIGH);
          end
        end
        pbe_pkg::PH_ORIGH: begin
          if (e) begin
            open_bar(int'(bar_sh) + 1);
          end else begin
            orig_hi = d;
            issue(pbe_pkg::KIND_WR, bar_offset() + 8'd4, 32'hffffffff, pbe_pkg::PH_WRH);
          end
        end
        pbe_pkg::PH_WRH:
          issue(pbe_pkg::KIND_WR, bar_offset(), 32'hffffffff, pbe_pkg::PH_WRL);
        pbe_pkg::PH_WRL: issue(pbe_pkg::KIND_RD, bar_offset(), 32'd0, pbe_pkg::PH_MASK);
        pbe_pkg::PH_MASK: begin
          mask_lo = e ? 32'd0 : d;
          if (bar_wide())
            issue(pbe_pkg::KIND_RD, bar_offset() + 8'd4, 32'd0, pbe_pkg::PH_MASKH);
          else issue(pbe_pkg::KIND_WR, bar_offset(), orig_lo, pbe_pkg::PH_RSTL);
        end
        pbe_pkg::PH_MASKH: begin
          mask_hi_bad = e;
          mask_hi = e ? 32'd0 : d;
          issue(pbe_pkg::KIND_WR, bar_offset(), orig_lo, pbe_pkg::PH_RSTL);
        end
        pbe_pkg::PH_RSTL: begin
          if (bar_wide())
            issue(pbe_pkg::KIND_WR, bar_offset() + 8'd4, orig_hi, pbe_pkg::PH_RSTH);
          else close_bar();
        end
        pbe_pkg::PH_RSTH: close_bar();
        default: phase_sh = pbe_pkg::PH_IDLE;
      endcase
    end
    if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last_of_run = 1'b1;
    foreach (step_beats[i]) want_beats.push_back(step_beats[i]);
  endfunction

  task automatic check_beat(pbe_pkg::out_item_t w);
    if (out_if.out_kind !== w.out_kind)
      $error("out_kind expected %0d got %0d", w.out_kind, out_if.out_kind);
    if (out_if.cfg_address !== w.cfg_address)
      $error("cfg_address expected %h got %h", w.cfg_address, out_if.cfg_address);
    if (out_if.data_word !== w.data_word)
      $error("data_word expected %h got %h", w.data_word, out_if.data_word);
    if (out_if.slot_num !== w.slot_num)
      $error("slot_num expected %0d got %0d", w.slot_num, out_if.slot_num);
    if (out_if.function_num !== w.function_num)
      $error("function_num expected %0d got %0d", w.function_num, out_if.function_num);
    if (out_if.bar_index !== w.bar_index)
      $error("bar_index expected %0d got %0d", w.bar_index, out_if.bar_index);
    if (out_if.bar_flags !== w.bar_flags)
      $error("bar_flags expected %0d got %0d", w.bar_flags, out_if.bar_flags);
    if (out_if.bar_size !== w.bar_size)
      $error("bar_size expected %h got %h", w.bar_size, out_if.bar_size);
    if (out_if.irq_info !== w.irq_info)
      $error("irq_info expected %h got %h", w.irq_info, out_if.irq_info);
    if (out_if.last_of_run !== w.last_of_run)
      $error("last_of_run expected %0d got %0d", w.last_of_run, out_if.last_of_run);
    if (out_if.out_kind !== w.out_kind || out_if.cfg_address !== w.cfg_address ||
        out_if.data_word !== w.data_word || out_if.slot_num !== w.slot_num ||
        out_if.function_num !== w.function_num || out_if.bar_index !== w.bar_index ||
        out_if.bar_flags !== w.bar_flags || out_if.bar_size !== w.bar_size ||
        out_if.irq_info !== w.irq_info || out_if.last_of_run !== w.last_of_run)
      mismatches++;
  endtask

  always @(posedge clk) begin
    in_took <= rst_n && in_if.valid && in_if.ready;
    if (rst_n && out_if.valid && out_if.ready) begin
      out_count++;
      if (want_beats.size() == 0) begin
        $error("result beat with nothing expected, out_kind %0d", out_if.out_kind);
        mismatches++;
      end else begin
        check_beat(want_beats.pop_front());
      end
    end
    if (rst_n && in_if.valid && in_if.ready)
      scan_step('{cmd: in_if.command, rsp_data: in_if.rsp_data, rsp_error: in_if.rsp_error});
  end

  always @(negedge clk) begin
    pbe_pkg::in_item_t it;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.command <= pbe_pkg::CMD_START;
      in_if.rsp_data <= 32'd0;
      in_if.rsp_error <= 1'b0;
    end else if (!in_if.valid || in_took) begin
      if (completion_q.size() > 0 && (calm || $urandom_range(0, 99) >= 10)) begin
        it = completion_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.command <= it.cmd;
        in_if.rsp_data <= it.rsp_data;
        in_if.rsp_error <= it.rsp_error;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  int hold_left = 0;
  logic hold_done = 1'b0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (!hold_done && !calm && out_count >= 10) begin
      hold_done <= 1'b1;
      hold_left <= 200;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  task automatic reg_write(logic [1:0] addr, logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == REG_BUS_NUMBER) bus_sh = value[7:0];
  endtask

  task automatic add(logic cmd, logic [31:0] data, logic err);
    completion_q.push_back('{cmd: cmd, rsp_data: data, rsp_error: err});
  endtask

  function automatic logic [31:0] pick_word();
    int k;
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hffffffff;
      2: return {16'hffff, 16'($urandom)};
      3, 4: return {$urandom} ;
      5, 6: begin
        k = $urandom_range(2, 31);
        return (32'hffffffff << k) | 32'($urandom_range(0, 15));
      end
      7: return {28'($urandom), 4'($urandom_range(0, 15))};
      8: return $urandom | 32'h0080_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic drain();
    do @(posedge clk);
    while (completion_q.size() > 0 || in_if.valid || want_beats.size() > 0);
    repeat (5) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = REG_BUS_NUMBER;
    cfg_pwdata = 32'd0;
    bus_sh = 8'd0;
    phase_sh = pbe_pkg::PH_IDLE;
    {slot_sh, fn_sh, multi_sh, bar_sh, id_sh, class_sh, irq_sh} = '0;
    {orig_lo, orig_hi, mask_lo, mask_hi, mask_hi_bad} = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    reg_write(REG_BUS_NUMBER, 32'hff);
    add(CMD_DONE_ACCESS, 32'h1234_5678, 1'b0);
    add(pbe_pkg::CMD_START, 32'd0, 1'b0);
    add(CMD_DONE_ACCESS, 32'h0080_0000, 1'b0);
    add(CMD_DONE_ACCESS, 32'h1234_8086, 1'b0);
    add(CMD_DONE_ACCESS, 32'h0c03_0001, 1'b0);
    add(CMD_DONE_ACCESS, 32'h0000_000b, 1'b0);
    add(CMD_DONE_ACCESS, 32'h0000_0100, 1'b0);
    add(CMD_DONE_ACCESS, 32'hfebf_000c, 1'b0);
    add(CMD_DONE_ACCESS, 32'h0000_0001, 1'b0);
    add(CMD_DONE_ACCESS, 32'd0, 1'b1);
    add(CMD_DONE_ACCESS, 32'd0, 1'b0);
    add(CMD_DONE_ACCESS, 32'hffff_c00c, 1'b0);
    add(CMD_DONE_ACCESS, 32'hffff_ffff, 1'b0);
    add(CMD_DONE_ACCESS, 32'd0, 1'b0);
    add(CMD_DONE_ACCESS, 32'd0, 1'b0);
    add(CMD_DONE_ACCESS, 32'h0000_e001, 1'b0);
    add(CMD_DONE_ACCESS, 32'd0, 1'b0);
    add(CMD_DONE_ACCESS, 32'hffff_ff01, 1'b0);
    add(CMD_DONE_ACCESS, 32'd0, 1'b0);
    add(CMD_DONE_ACCESS, 32'hffff_ffff, 1'b1);
    add(CMD_DONE_ACCESS, 32'd0, 1'b0);
    add(CMD_DONE_ACCESS, 32'h0000_0004, 1'b0);
    add(CMD_DONE_ACCESS, 32'h0000_0000, 1'b1);
    add(CMD_DONE_ACCESS, 32'h0000_0000, 1'b0);
    add(pbe_pkg::CMD_START, 32'hffff_ffff, 1'b1);
    drain();

    // Empty bus walked to the end with no stalls on either side.
    reg_write(REG_BUS_NUMBER, 32'h00);
    calm = 1'b1;
    add(pbe_pkg::CMD_START, 32'd0, 1'b0);
    for (int s = 0; s < SLOT_COUNT; s++) begin
      add(CMD_DONE_ACCESS, $urandom & 32'hff7f_ffff, 1'b0);
      add(CMD_DONE_ACCESS, {16'($urandom), 16'hffff}, 1'b0);
      add(CMD_DONE_ACCESS, $urandom, 1'($urandom_range(0, 1)));
    end
    add(CMD_DONE_ACCESS, $urandom, 1'b0);
    drain();
    calm = 1'b0;

    reg_write(REG_BUS_NUMBER, {24'd0, 8'($urandom)});
    add(pbe_pkg::CMD_START, 32'd0, 1'b0);
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(0, 99) < 2) add(pbe_pkg::CMD_START, $urandom, 1'($urandom));
      else add(CMD_DONE_ACCESS, pick_word(), $urandom_range(0, 99) < 6);
    end
    drain();

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pbe_pkg.sv
rtl/pbe_if.sv
rtl/pbe_core.sv
rtl/pbe_outq.sv
rtl/pci_bus_enumeration_bar_sizing.sv
sim/pci_bus_enumeration_bar_sizing_tb.sv
